>>> sv/matrix_multiply_engine_core_macros.svh
// Assertion helpers for the matrix multiply engine checkers.
`ifndef MATRIX_MULTIPLY_ENGINE_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define MME_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MME_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/mme_pkg.sv
package mme_pkg;

   localparam int POS_W         = 10;
   localparam int CMD_W         = 2;
   localparam int OPER_IN_W     = 16;
   localparam int RESULT_W      = 32;
   localparam int DIM_REG_W     = 6;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;
   localparam int ACC_W         = 42;  // holds +-2^40 clamp bound
   localparam int ACC_BOUND_BIT = 40;

   localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   localparam logic [1:0] CSR_ROW_COUNT   = 2'd0;
   localparam logic [1:0] CSR_INNER_COUNT = 2'd1;
   localparam logic [1:0] CSR_COL_COUNT   = 2'd2;

   localparam logic [DIM_REG_W-1:0] DIM_RESET = 6'd32;

   // accumulator pipeline control, aligned with store read data
   typedef struct packed {
      logic clear;
      logic valid;
      logic last;
   } mac_ctl_type;

endpackage

>>> sv/matrix_multiply_engine_core.sv
// Channel   Ports                                  Handshake
// --------  -------------------------------------  -------------------------------
// request   req_command, req_position, req_operand beat taken on start & !busy
// result    rsp_product, rsp_result_position,      rsp_valid strobe, one cycle
//           rsp_saturated, rsp_out_of_range
// config    psel, penable, pwrite, paddr, pwdata,  APB write on psel&penable&pwrite
//           prdata, pready                         pready tied high
//
// Load beats write the element to its store at the accept edge; busy never rises.
// A compute beat holds busy through a range check, a shift-subtract divide for
// row/col with a hand-off, a base-address step, one store read per k, then a
// drain of the read/multiply/accumulate pipeline. Out-of-range positions drop
// busy after the range check and answer from the result register.
// Reset is synchronous and clears control and config; store contents are undefined
// until loaded. The result strobe cannot be stalled.
module matrix_multiply_engine_core #(
   parameter int MAX_DIM      = 32,
   parameter int OPERAND_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    start,
   output logic                                    busy,
   input  logic [mme_pkg::CMD_W-1:0]               req_command,
   input  logic [mme_pkg::POS_W-1:0]               req_position,
   input  logic signed [mme_pkg::OPER_IN_W-1:0]    req_operand,
   // result channel
   output logic                                    rsp_valid,
   output logic signed [mme_pkg::RESULT_W-1:0]     rsp_product,
   output logic [mme_pkg::POS_W-1:0]               rsp_result_position,
   output logic                                    rsp_saturated,
   output logic                                    rsp_out_of_range,
   // configuration port
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [mme_pkg::CSR_ADDR_W-1:0]          paddr,
   input  logic [mme_pkg::CSR_DATA_W-1:0]          pwdata,
   output logic [mme_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                    pready
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int POS_W  = mme_pkg::POS_W;
   localparam int REG_W  = mme_pkg::DIM_REG_W;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_DIVIDE = 6'b000100,
      ST_BASE   = 6'b001000,
      ST_MAC    = 6'b010000,
      ST_DRAIN  = 6'b100000
   } state_type;

   // register value 0 acts as 1, above MAX_DIM acts as MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_W-1:0] raw);
      logic [DIM_W-1:0] v;
      if (raw == '0) begin
         v = DIM_W'(1);
      end else if (32'(raw) > MAX_DIM) begin
         v = DIM_W'(MAX_DIM);
      end else begin
         v = DIM_W'(raw);
      end
      return v;
   endfunction

   state_type state_ff, state_in;

   // configuration registers
   logic [REG_W-1:0] row_count_ff, inner_count_ff, col_count_ff;
   logic             csr_write;
   logic [1:0]       csr_index;

   logic [DIM_W-1:0] rows_eff, inner_eff, cols_eff;
   logic [2*DIM_W-1:0] area;

   logic             accept;
   logic             load_ok;
   logic             wr_a, wr_b;
   logic [ADDR_W-1:0]       wr_addr;
   logic [OPERAND_BITS-1:0] wr_data;

   // compute context
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DIM_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic [ADDR_W-1:0] a_addr_ff, a_addr_in, b_addr_ff, b_addr_in;
   logic [DIM_W-1:0]  k_ff, k_in;
   logic              k_last;
   logic              rd_en;
   logic              rd_valid_ff, rd_last_ff;

   logic                    div_start, div_done;
   logic [POS_W-1:0]        div_quo;
   logic [DIM_W-1:0]        div_rem;

   logic [OPERAND_BITS-1:0] a_rd, b_rd;
   mme_pkg::mac_ctl_type    mac_ctl;
   logic                    mac_clear;
   logic                    mac_done, mac_sat;
   logic signed [mme_pkg::RESULT_W-1:0] mac_product;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [mme_pkg::RESULT_W-1:0] rsp_product_ff, rsp_product_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic                 rsp_sat_ff, rsp_sat_in;
   logic                 rsp_oor_ff, rsp_oor_in;

   // ---------------- configuration ----------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= mme_pkg::DIM_RESET;
         inner_count_ff <= mme_pkg::DIM_RESET;
         col_count_ff   <= mme_pkg::DIM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            mme_pkg::CSR_ROW_COUNT:   row_count_ff   <= pwdata[REG_W-1:0];
            mme_pkg::CSR_INNER_COUNT: inner_count_ff <= pwdata[REG_W-1:0];
            mme_pkg::CSR_COL_COUNT:   col_count_ff   <= pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         mme_pkg::CSR_ROW_COUNT:   prdata = mme_pkg::CSR_DATA_W'(row_count_ff);
         mme_pkg::CSR_INNER_COUNT: prdata = mme_pkg::CSR_DATA_W'(inner_count_ff);
         mme_pkg::CSR_COL_COUNT:   prdata = mme_pkg::CSR_DATA_W'(col_count_ff);
         default:                  prdata = '0;
      endcase
   end

   // Users write config only while idle (unenforced): clamped sizes hold per compute.
   assign rows_eff  = clamp_dim(row_count_ff);
   assign inner_eff = clamp_dim(inner_count_ff);
   assign cols_eff  = clamp_dim(col_count_ff);
   assign area      = rows_eff * cols_eff;

   // ---------------- loads ----------------
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start & ~busy;
   assign load_ok = (32'(req_position) < DEPTH);
   assign wr_a    = accept & load_ok & (req_command == mme_pkg::CMD_LOAD_A);
   assign wr_b    = accept & load_ok & (req_command == mme_pkg::CMD_LOAD_B);
   assign wr_addr = ADDR_W'(req_position);
   // Q8.8 input sign-extended (or cut) to the store width
   assign wr_data = OPERAND_BITS'(req_operand);

   // Loads only land while idle and reads only run while busy, so the stores
   // never see a read and write to the same entry in flight: no forwarding.
   mme_store #(.WIDTH(OPERAND_BITS), .DEPTH(DEPTH)) u_a_store (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (a_addr_ff),
      .rd_data (a_rd)
   );

   mme_store #(.WIDTH(OPERAND_BITS), .DEPTH(DEPTH)) u_b_store (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (b_addr_ff),
      .rd_data (b_rd)
   );

   // ---------------- row / col split ----------------
   mme_div #(.DIVIDEND_W(POS_W), .DIVISOR_W(DIM_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (pos_ff),
      .divisor   (cols_eff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // ---------------- sequencer ----------------
   assign k_last = (k_ff == DIM_W'(inner_eff - 1'b1));
   assign rd_en  = (state_ff == ST_MAC);

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      a_addr_in      = a_addr_ff;
      b_addr_in      = b_addr_ff;
      k_in           = k_ff;
      div_start      = 1'b0;
      mac_clear      = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_product_in = rsp_product_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_sat_in     = rsp_sat_ff;
      rsp_oor_in     = rsp_oor_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == mme_pkg::CMD_COMPUTE) begin
               pos_in   = req_position;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (32'(pos_ff) >= 32'(area)) begin
               rsp_valid_in   = 1'b1;
               rsp_product_in = '0;
               rsp_pos_in     = pos_ff;
               rsp_sat_in     = 1'b0;
               rsp_oor_in     = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               // quotient is below rows_eff here, so it fits the row width
               row_in   = DIM_W'(div_quo);
               col_in   = div_rem;
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            a_addr_in = ADDR_W'(row_ff * inner_eff);
            b_addr_in = ADDR_W'(col_ff);
            k_in      = '0;
            mac_clear = 1'b1;
            state_in  = ST_MAC;
         end
         ST_MAC: begin
            // A walks along the row, B steps down the column
            a_addr_in = a_addr_ff + 1'b1;
            b_addr_in = b_addr_ff + ADDR_W'(cols_eff);
            k_in      = k_ff + 1'b1;
            if (k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               rsp_valid_in   = 1'b1;
               rsp_product_in = mac_product;
               rsp_pos_in     = pos_ff;
               rsp_sat_in     = mac_sat;
               rsp_oor_in     = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rd_last_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_en;
         rd_last_ff   <= rd_en & k_last;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      row_ff         <= row_in;
      col_ff         <= col_in;
      a_addr_ff      <= a_addr_in;
      b_addr_ff      <= b_addr_in;
      k_ff           <= k_in;
      rsp_product_ff <= rsp_product_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_sat_ff     <= rsp_sat_in;
      rsp_oor_ff     <= rsp_oor_in;
   end

   // ---------------- multiply / accumulate ----------------
   // read data returns in the cycle after issue; valid/last tags ride alongside
   assign mac_ctl.clear = mac_clear;
   assign mac_ctl.valid = rd_valid_ff;
   assign mac_ctl.last  = rd_last_ff;

   mme_mac #(.OPERAND_BITS(OPERAND_BITS)) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .a_data    (a_rd),
      .b_data    (b_rd),
      .done      (mac_done),
      .product   (mac_product),
      .saturated (mac_sat)
   );

   // ---------------- result beat ----------------
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_product         = rsp_product_ff;
   assign rsp_result_position = rsp_pos_ff;
   assign rsp_saturated       = rsp_sat_ff;
   assign rsp_out_of_range    = rsp_oor_ff;

endmodule

>>> sv/mme_store.sv
module mme_store #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/mme_div.sv
// Restoring divider, one quotient bit per cycle.
module mme_div #(
   parameter int DIVIDEND_W = 10,
   parameter int DIVISOR_W  = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    partial;
   logic                  fits;

   assign partial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits    = partial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? DIVISOR_W'(partial - {1'b0, divisor}) : DIVISOR_W'(partial);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> sv/mme_mac.sv
// Multiply stage, then clamped accumulate; saturates the final sum to Q16.16.
module mme_mac #(
   parameter int OPERAND_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mme_pkg::mac_ctl_type                 ctl,
   input  logic signed [OPERAND_BITS-1:0]       a_data,
   input  logic signed [OPERAND_BITS-1:0]       b_data,
   output logic                                 done,
   output logic signed [mme_pkg::RESULT_W-1:0]  product,
   output logic                                 saturated
);

   localparam int ACC_W  = mme_pkg::ACC_W;
   localparam int PROD_W = 2 * OPERAND_BITS;
   localparam int SUM_W  = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 1;
   localparam logic signed [SUM_W-1:0] BOUND =
      {{(SUM_W - mme_pkg::ACC_BOUND_BIT - 1){1'b0}}, 1'b1, {mme_pkg::ACC_BOUND_BIT{1'b0}}};
   localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32'sh7fffffff);
   localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(32'sh80000000);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     pvalid_ff, plast_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     done_ff;
   logic signed [SUM_W-1:0]  sum;

   assign sum = SUM_W'(acc_ff) + SUM_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (pvalid_ff) begin
         if (sum > BOUND) begin
            acc_in = ACC_W'(BOUND);
         end else if (sum < -BOUND) begin
            acc_in = ACC_W'(-BOUND);
         end else begin
            acc_in = ACC_W'(sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_data * b_data;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         plast_ff  <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         pvalid_ff <= ctl.valid;
         plast_ff  <= ctl.valid & ctl.last;
         done_ff   <= pvalid_ff & plast_ff;
      end
   end

   always_comb begin
      saturated = 1'b0;
      product   = acc_ff[mme_pkg::RESULT_W-1:0];
      if (acc_ff > Q_MAX) begin
         saturated = 1'b1;
         product   = 32'sh7fffffff;
      end else if (acc_ff < Q_MIN) begin
         saturated = 1'b1;
         product   = 32'sh80000000;
      end
   end

   assign done = done_ff;

endmodule

>>> sv/mme_checker.sv
`include "matrix_multiply_engine_core_macros.svh"

module mme_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic [mme_pkg::CMD_W-1:0]            req_command,
   input logic                                 rsp_valid,
   input logic signed [mme_pkg::RESULT_W-1:0]  rsp_product,
   input logic                                 rsp_saturated,
   input logic                                 rsp_out_of_range
);

   logic oor_beat, oor_clean, sat_beat, at_rail, take_compute, take_other;

   assign oor_beat     = rsp_valid & rsp_out_of_range;
   assign oor_clean    = (rsp_product == '0) & ~rsp_saturated;
   assign sat_beat     = rsp_valid & rsp_saturated;
   assign at_rail      = (rsp_product == 32'sh7fffffff) | (rsp_product == 32'sh80000000);
   assign take_compute = start & ~busy & (req_command == mme_pkg::CMD_COMPUTE);
   assign take_other   = start & ~busy & (req_command != mme_pkg::CMD_COMPUTE);

   // out-of-range beats carry a zero, unsaturated product
   `MME_ASSERT_SAME(a_oor_zero, clock, reset, oor_beat, oor_clean)

   // saturated beats sit at a Q16.16 rail
   `MME_ASSERT_SAME(a_sat_rail, clock, reset, sat_beat, at_rail)

   // one compute in flight: result strobes never run back to back
   `MME_ASSERT_NEXT(a_single_beat, clock, reset, rsp_valid, !rsp_valid)

   // a compute beat holds the request side off
   `MME_ASSERT_NEXT(a_compute_busy, clock, reset, take_compute, busy)

   // loads and the unused code produce no result
   `MME_ASSERT_NEXT(a_load_silent, clock, reset, take_other, !rsp_valid)

endmodule

bind matrix_multiply_engine_core mme_checker u_mme_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_command      (req_command),
   .rsp_valid        (rsp_valid),
   .rsp_product      (rsp_product),
   .rsp_saturated    (rsp_saturated),
   .rsp_out_of_range (rsp_out_of_range)
);
